[design/pdfe_pkg.sv]
// Package with the shared types and constants of the price display frame encoder.
package pdfe_pkg;

    // Frame geometry.
    localparam int SLOT_COUNT = 14;
    localparam int SLOT_W     = 4;

    // Digit codes sent in the high nibble of a slot byte.
    localparam logic [3:0] CODE_L     = 4'hA;
    localparam logic [3:0] CODE_BLANK = 4'hF;

    // Slots where the latch clock is held high, and the pause that follows them.
    localparam logic [SLOT_W-1:0] HOLD_SHORT_SLOT = 4'd7;
    localparam logic [SLOT_W-1:0] HOLD_LONG_SLOT  = 4'd10;
    localparam logic [SLOT_W-1:0] LAST_SLOT       = SLOT_W'(SLOT_COUNT - 1);

    // Pause kinds: the short pause is 246 us, the long pause 1863 us on the pins.
    localparam logic [1:0] PAUSE_NONE  = 2'd0;
    localparam logic [1:0] PAUSE_SHORT = 2'd1;
    localparam logic [1:0] PAUSE_LONG  = 2'd2;

    // Display modes.
    localparam logic MODE_PRICE = 1'b0;
    localparam logic MODE_TOTAL = 1'b1;

    // Binary to decimal conversion lanes.
    localparam int LANE_COUNT    = 3;
    localparam int LANE_TP       = 0;
    localparam int LANE_UP       = 1;
    localparam int LANE_VOL      = 2;
    localparam int VALUE_W       = 64;
    localparam int DIGITS        = 13;
    localparam int BITS_PER_STEP = 4;
    localparam int STEP_COUNT    = VALUE_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(STEP_COUNT + 1);

    // Digit groups: length and rightmost slot.
    localparam int TP_DIGITS  = 8;
    localparam int UP_DIGITS  = 6;
    localparam int VOL_DIGITS = 7;
    localparam int TP_LAST    = 7;
    localparam int UP_LAST    = 13;
    localparam int VOL_LAST   = 7;

    // Largest values that fit their digit groups.
    localparam logic [31:0] TP_MAX  = 32'd99999999;
    localparam logic [31:0] UP_MAX  = 32'd999999;
    localparam logic [31:0] VOL_MAX = 32'd9999999;
    localparam logic [63:0] TZ_MAX  = 64'd9999999999999;

    typedef logic [DIGITS-1:0][3:0] digits_t;
    typedef logic [LANE_COUNT-1:0][DIGITS-1:0][3:0] lane_digits_t;

    // One decoded frame: digit codes per slot for both lines and the overflow flag.
    typedef struct packed {
        logic [SLOT_COUNT-1:0][3:0] l1;
        logic [SLOT_COUNT-1:0][3:0] l2;
        logic                       ovf;
    } frame_t;

endpackage

[design/pdfe_if.sv]
// Handshake interfaces for the display update input and the frame slot output.
interface pdfe_upd_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] unit_rate;
    logic [31:0] sale_total;
    logic [31:0] volume;
    logic [63:0] totalizer;

    modport source (output valid, opcode, unit_rate, sale_total, volume, totalizer,
                    input ready);
    modport sink (input valid, opcode, unit_rate, sale_total, volume, totalizer,
                  output ready);
endinterface

interface pdfe_slot_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot_index;
    logic [7:0] line1_byte;
    logic [7:0] line2_byte;
    logic       hold_latch;
    logic [1:0] pause_kind;
    logic       overflow;
    logic       last;

    modport source (output valid, slot_index, line1_byte, line2_byte, hold_latch,
                    pause_kind, overflow, last, input ready);
    modport sink (input valid, slot_index, line1_byte, line2_byte, hold_latch,
                  pause_kind, overflow, last, output ready);
endinterface

[design/price_display_frame_encoder.sv]
// Top level of the price display frame encoder.
// Each accepted update yields a frame of 14 slot items, slot 0 first, slot 13 flagged
// as last. Three conversion lanes turn total price, unit price and volume (or the
// totalizer, in totalizer mode) into decimal digits at four input bits per cycle; a new
// update is taken while the lanes are idle or as the result of the last one loads into
// the emitter. A finished frame sits in the emitter's frame register, so the lanes
// convert the next update while the current frame is still being sent; output stalls
// hold the frame, and the lanes wait with their result until the emitter is free.
module price_display_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    pdfe_upd_if.sink    update,
    pdfe_slot_if.source frame
);
    import pdfe_pkg::*;

    logic                      busy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      mode_reg;
    logic [LANE_COUNT-1:0]     ovf_reg;
    logic                      accept;
    logic                      finished;
    logic                      can_load;
    logic                      load_frame;
    logic [LANE_COUNT-1:0][VALUE_W-1:0] lane_value;
    lane_digits_t              lane_digits;
    frame_t                    merged;

    assign finished     = busy_reg && (cnt_reg == CNT_W'(STEP_COUNT));
    assign load_frame   = finished && can_load;
    assign update.ready = !busy_reg || load_frame;
    assign accept       = update.valid && update.ready;

    // Lane inputs: lane 0 carries the totalizer in totalizer mode.
    assign lane_value[LANE_TP]  = (update.opcode == MODE_TOTAL) ? update.totalizer
                                : {32'd0, update.sale_total};
    assign lane_value[LANE_UP]  = {32'd0, update.unit_rate};
    assign lane_value[LANE_VOL] = {32'd0, update.volume};

    // Conversion control: the load does the first step, the rest follow one a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(1);
        end
        else if (load_frame)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && !finished)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Mode and overflow flags of the update in conversion.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg          <= update.opcode;
            ovf_reg[LANE_TP]  <= (update.opcode == MODE_TOTAL) ?
                                 (update.totalizer > TZ_MAX) : (update.sale_total > TP_MAX);
            ovf_reg[LANE_UP]  <= update.unit_rate > UP_MAX;
            ovf_reg[LANE_VOL] <= update.volume > VOL_MAX;
        end
    end

    // Conversion lanes.
    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        pdfe_lane u_lane (
            .clk    (clk),
            .load   (accept),
            .step   (busy_reg && !finished),
            .value  (lane_value[g]),
            .digits (lane_digits[g])
        );
    end

    pdfe_merge u_merge (
        .mode        (mode_reg),
        .lane_ovf    (ovf_reg),
        .lane_digits (lane_digits),
        .frame       (merged)
    );

    pdfe_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load_frame),
        .frame_in (merged),
        .can_load (can_load),
        .slot     (frame)
    );

    // A frame is never cut short once it has started.
    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready && !frame.last |=> frame.valid)
        else $error("frame dropped before its last slot");

    // Slots of one frame leave in order.
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready && !frame.last |=>
            frame.slot_index == 4'($past(frame.slot_index) + 4'd1))
        else $error("slot index did not advance by one");

    // The lanes are busy right after taking an update.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        update.valid && update.ready |=> !update.ready)
        else $error("update taken while conversion in progress");

    // The overflow flag stays fixed across one frame.
    a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready && !frame.last |=> $stable(frame.overflow))
        else $error("overflow changed within a frame");

endmodule

[design/pdfe_lane.sv]
// One conversion lane: shift-and-add-3 binary to decimal, four input bits per cycle of load or step.
module pdfe_lane (
    input  logic                           clk,
    input  logic                           load,
    input  logic                           step,
    input  logic [pdfe_pkg::VALUE_W-1:0]   value,
    output pdfe_pkg::digits_t              digits
);
    import pdfe_pkg::*;

    localparam int BCD_W = DIGITS * 4;

    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [VALUE_W-1:0] sh_reg;
    logic [VALUE_W-1:0] sh_next;

    // Several double-dabble bit steps; digits above the kept count fall off the top,
    // which leaves the value modulo ten to the power of the digit count.
    function automatic logic [BCD_W+VALUE_W-1:0] dabble(
        input logic [BCD_W-1:0]   bcd_in,
        input logic [VALUE_W-1:0] sh_in
    );
        logic [BCD_W-1:0]   b;
        logic [VALUE_W-1:0] s;
        b = bcd_in;
        s = sh_in;
        for (int bit_i = 0; bit_i < BITS_PER_STEP; bit_i++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (b[d*4 +: 4] >= 4'd5)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], s[VALUE_W-1]};
            s = {s[VALUE_W-2:0], 1'b0};
        end
        return {b, s};
    endfunction

    // A load already performs the first step on the new value.
    always_comb
    begin
        if (load)
        begin
            {bcd_next, sh_next} = dabble('0, value);
        end
        else if (step)
        begin
            {bcd_next, sh_next} = dabble(bcd_reg, sh_reg);
        end
        else
        begin
            bcd_next = bcd_reg;
            sh_next  = sh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        sh_reg  <= sh_next;
    end

    assign digits = bcd_reg;

endmodule

[design/pdfe_merge.sv]
// Merge stage: places the lane digits into frame slots with blanking and fixed codes.
module pdfe_merge (
    input  logic                              mode,
    input  logic [pdfe_pkg::LANE_COUNT-1:0]   lane_ovf,
    input  pdfe_pkg::lane_digits_t            lane_digits,
    output pdfe_pkg::frame_t                  frame
);
    import pdfe_pkg::*;

    logic [LANE_COUNT-1:0][DIGITS-1:0] nz;

    // A digit is shown when it or any more significant digit of the lane is nonzero.
    always_comb
    begin
        for (int l = 0; l < LANE_COUNT; l++)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                nz[l][k] = |(lane_digits[l] >> (4 * k));
            end
        end
    end

    // The rightmost digit of a group always shows; an overflowed value shows all digits.
    function automatic logic [3:0] pick(
        input digits_t             d,
        input logic [DIGITS-1:0]   nzv,
        input int                  pos,
        input int                  base,
        input logic                ovf
    );
        logic show;
        show = (pos == base) || ovf || nzv[pos];
        return show ? d[pos] : CODE_BLANK;
    endfunction

    always_comb
    begin
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            frame.l1[s] = CODE_BLANK;
            frame.l2[s] = CODE_BLANK;
        end
        if (mode == MODE_PRICE)
        begin
            for (int k = 0; k < TP_DIGITS; k++)
            begin
                frame.l1[TP_LAST - k] =
                    pick(lane_digits[LANE_TP], nz[LANE_TP], k, 0, lane_ovf[LANE_TP]);
            end
            for (int k = 0; k < UP_DIGITS; k++)
            begin
                frame.l1[UP_LAST - k] =
                    pick(lane_digits[LANE_UP], nz[LANE_UP], k, 0, lane_ovf[LANE_UP]);
            end
            for (int k = 0; k < VOL_DIGITS; k++)
            begin
                frame.l2[VOL_LAST - k] =
                    pick(lane_digits[LANE_VOL], nz[LANE_VOL], k, 0, lane_ovf[LANE_VOL]);
            end
            frame.ovf = |lane_ovf;
        end
        else
        begin
            // Totalizer: "LL" in front, low six digits on line 1, next seven on line 2.
            frame.l1[0] = CODE_L;
            frame.l1[1] = CODE_L;
            for (int k = 0; k < UP_DIGITS; k++)
            begin
                frame.l1[UP_LAST - k] =
                    pick(lane_digits[LANE_TP], nz[LANE_TP], k, 0, lane_ovf[LANE_TP]);
            end
            for (int k = 0; k < VOL_DIGITS; k++)
            begin
                frame.l2[VOL_LAST - k] =
                    pick(lane_digits[LANE_TP], nz[LANE_TP], UP_DIGITS + k, UP_DIGITS,
                         lane_ovf[LANE_TP]);
            end
            frame.ovf = lane_ovf[LANE_TP];
        end
    end

endmodule

[design/pdfe_emit.sv]
// Frame emitter: holds one decoded frame and sends its slots in order.
module pdfe_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pdfe_pkg::frame_t  frame_in,
    output logic              can_load,
    pdfe_slot_if.source       slot
);
    import pdfe_pkg::*;

    frame_t              frame_reg;
    logic                valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                fire;
    logic                at_last;

    assign fire     = slot.valid && slot.ready;
    assign at_last  = (slot_reg == LAST_SLOT);
    assign can_load = !valid_reg || (fire && at_last);

    // Frame storage; a new frame may load as the last slot of the old one leaves.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_in;
        end
    end

    // Slot counter and frame valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            slot_reg  <= '0;
        end
        else if (fire)
        begin
            if (at_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // Slot payload.
    assign slot.valid      = valid_reg;
    assign slot.slot_index = slot_reg;
    assign slot.line1_byte = {frame_reg.l1[slot_reg], slot_reg};
    assign slot.line2_byte = {frame_reg.l2[slot_reg], slot_reg};
    assign slot.hold_latch = (slot_reg == HOLD_SHORT_SLOT) || (slot_reg == HOLD_LONG_SLOT);
    assign slot.overflow   = frame_reg.ovf;
    assign slot.last       = at_last;

    always_comb
    begin
        if (slot_reg == HOLD_SHORT_SLOT)
        begin
            slot.pause_kind = PAUSE_SHORT;
        end
        else if (slot_reg == HOLD_LONG_SLOT)
        begin
            slot.pause_kind = PAUSE_LONG;
        end
        else
        begin
            slot.pause_kind = PAUSE_NONE;
        end
    end

endmodule

[sim/price_display_frame_encoder_test.sv]
// Self-checking testbench for the price display frame encoder: directed and random updates.
module price_display_frame_encoder_test;
    import pdfe_pkg::*;

    localparam int RANDOM_UPDATES  = 411;
    localparam int MAX_WAIT        = 17;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int UP_FIRST        = UP_LAST - UP_DIGITS + 1;
    localparam int TP_FIRST        = TP_LAST - TP_DIGITS + 1;
    localparam int VOL_FIRST       = VOL_LAST - VOL_DIGITS + 1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] unit_rate;
        logic [31:0] sale_total;
        logic [31:0] volume;
        logic [63:0] totalizer;
    } update_t;

    typedef struct packed {
        logic [3:0] slot_index;
        logic [7:0] line1_byte;
        logic [7:0] line2_byte;
        logic       hold_latch;
        logic [1:0] pause_kind;
        logic       overflow;
        logic       last;
    } slot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pdfe_upd_if  upd_bus ();
    pdfe_slot_if slot_bus ();

    // Testbench-side registers hold every block input at a known value from time zero.
    update_t offer       = '0;
    logic    offer_valid = 1'b0;
    logic    take_ready  = 1'b0;

    assign upd_bus.valid      = offer_valid;
    assign upd_bus.opcode     = offer.opcode;
    assign upd_bus.unit_rate  = offer.unit_rate;
    assign upd_bus.sale_total = offer.sale_total;
    assign upd_bus.volume     = offer.volume;
    assign upd_bus.totalizer  = offer.totalizer;
    assign slot_bus.ready     = take_ready;

    update_t pending_updates[$];
    slot_t   expected_slots[$];
    int      total_updates = 0;
    int      updates_taken = 0;
    int      slots_seen    = 0;
    int      error_count   = 0;

    price_display_frame_encoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (upd_bus),
        .frame  (slot_bus)
    );

    always #5 clk = ~clk;

    // Power of ten as a 64-bit value.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        int          i;
        p = 64'd1;
        for (i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // Random value for a digit group: zero, group maximum, first overflow, a power of ten,
    // full-width noise, or mostly a random number of digits.
    function automatic logic [63:0] random_shown_value(input int digits, input int width);
        logic [63:0] v;
        logic [63:0] mask;
        mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
        case ($urandom_range(0, 15))
            0: v = 64'd0;
            1: v = pow10(digits) - 64'd1;
            2: v = pow10(digits);
            3: v = {$urandom, $urandom};
            4: v = pow10($urandom_range(1, digits - 1));
            default: v = {$urandom, $urandom} % pow10($urandom_range(1, digits));
        endcase
        return v & mask;
    endfunction

    // Fill one digit group from its rightmost slot leftward; a spent value leaves
    // a single 0 at the right and blanks to the left.
    function automatic void spread_decimal(inout logic [SLOT_COUNT-1:0][3:0] line,
                                           input int lo, input int hi,
                                           inout logic [63:0] rest);
        int i;
        for (i = hi; i >= lo; i--)
        begin
            if (rest != 64'd0)
            begin
                line[i] = 4'(rest % 64'd10);
                rest    = rest / 64'd10;
            end
            else if (i == hi)
                line[i] = 4'd0;
            else
                line[i] = CODE_BLANK;
        end
    endfunction

    // Work out the 14 slot items of one update and queue them.
    function automatic void predict_frame(input update_t u);
        logic [SLOT_COUNT-1:0][3:0] l1;
        logic [SLOT_COUNT-1:0][3:0] l2;
        logic [63:0]                rest;
        logic                       ovf;
        slot_t                      s;
        int                         i;
        l1 = {SLOT_COUNT{CODE_BLANK}};
        l2 = {SLOT_COUNT{CODE_BLANK}};
        if (u.opcode == MODE_PRICE)
        begin
            ovf = (u.unit_rate > UP_MAX) || (u.sale_total > TP_MAX) || (u.volume > VOL_MAX);
            rest = 64'(u.unit_rate);
            spread_decimal(l1, UP_FIRST, UP_LAST, rest);
            rest = 64'(u.sale_total);
            spread_decimal(l1, TP_FIRST, TP_LAST, rest);
            rest = 64'(u.volume);
            spread_decimal(l2, VOL_FIRST, VOL_LAST, rest);
        end
        else
        begin
            // The totalizer spills from the line 1 group into the line 2 group.
            ovf = u.totalizer > TZ_MAX;
            l1[0] = CODE_L;
            l1[1] = CODE_L;
            rest = u.totalizer;
            spread_decimal(l1, UP_FIRST, UP_LAST, rest);
            spread_decimal(l2, VOL_FIRST, VOL_LAST, rest);
        end
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            s.slot_index = SLOT_W'(i);
            s.line1_byte = {l1[i], s.slot_index};
            s.line2_byte = {l2[i], s.slot_index};
            s.hold_latch = (s.slot_index == HOLD_SHORT_SLOT) || (s.slot_index == HOLD_LONG_SLOT);
            s.pause_kind = (s.slot_index == HOLD_SHORT_SLOT) ? PAUSE_SHORT :
                           (s.slot_index == HOLD_LONG_SLOT)  ? PAUSE_LONG  : PAUSE_NONE;
            s.overflow   = ovf;
            s.last       = (s.slot_index == LAST_SLOT);
            expected_slots.push_back(s);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare one received slot item with the oldest one predicted.
    function automatic void check_slot(input slot_t got);
        slot_t want;
        if (expected_slots.size() == 0)
        begin
            $error("slot item %0d arrived with no item predicted", got.slot_index);
            error_count++;
        end
        else
        begin
            want = expected_slots.pop_front();
            compare_field("slot_index", 8'(want.slot_index), 8'(got.slot_index));
            compare_field("line1_byte", want.line1_byte, got.line1_byte);
            compare_field("line2_byte", want.line2_byte, got.line2_byte);
            compare_field("hold_latch", 8'(want.hold_latch), 8'(got.hold_latch));
            compare_field("pause_kind", 8'(want.pause_kind), 8'(got.pause_kind));
            compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
            compare_field("last", 8'(want.last), 8'(got.last));
        end
    endfunction

    // Per-item wait, in runs that are either free of idling or idle at random.
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(6, 40);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void queue_update(input logic op, input logic [31:0] up,
                                         input logic [31:0] tp, input logic [31:0] vol,
                                         input logic [63:0] tz);
        update_t u;
        u.opcode     = op;
        u.unit_rate  = up;
        u.sale_total = tp;
        u.volume     = vol;
        u.totalizer  = tz;
        pending_updates.push_back(u);
    endfunction

    // Update driver: offers queued updates, predicting each frame when it is taken.
    int send_gap  = 0;
    int send_run  = 0;
    bit send_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offer_valid <= 1'b0;
        end
        else
        begin
            if (offer_valid && upd_bus.ready)
            begin
                predict_frame(offer);
                updates_taken++;
                send_gap = draw_wait(send_run, send_calm);
            end
            if (!offer_valid || upd_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    offer_valid <= 1'b0;
                end
                else if (pending_updates.size() > 0)
                begin
                    offer       <= pending_updates.pop_front();
                    offer_valid <= 1'b1;
                end
                else
                begin
                    offer_valid <= 1'b0;
                end
            end
        end
    end

    // Slot monitor: checks each slot item taken and stalls at random; twice it holds off
    // for a long stretch so that the block fills up and pushes back on updates.
    int take_wait = 0;
    int take_run  = 0;
    bit take_calm = 1'b0;
    int hold_off  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (slot_bus.valid && take_ready)
            begin
                check_slot('{slot_index: slot_bus.slot_index,
                             line1_byte: slot_bus.line1_byte,
                             line2_byte: slot_bus.line2_byte,
                             hold_latch: slot_bus.hold_latch,
                             pause_kind: slot_bus.pause_kind,
                             overflow:   slot_bus.overflow,
                             last:       slot_bus.last});
                slots_seen++;
                take_wait = draw_wait(take_run, take_calm);
                if (slots_seen == 300 || slots_seen == 3000)
                    hold_off = HOLD_OFF_CYCLES;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                take_ready <= 1'b0;
            end
            else if (take_wait > 0)
            begin
                take_wait--;
                take_ready <= 1'b0;
            end
            else
            begin
                take_ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int      i;
        update_t u;

        // Price mode: zero, group maxima, each first overflow alone, full width, sparse digits.
        queue_update(MODE_PRICE, 32'd0, 32'd0, 32'd0, 64'd0);
        queue_update(MODE_PRICE, UP_MAX, TP_MAX, VOL_MAX, '1);
        queue_update(MODE_PRICE, UP_MAX + 32'd1, 32'd0, 32'd0, 64'd0);
        queue_update(MODE_PRICE, 32'd0, TP_MAX + 32'd1, 32'd0, 64'd0);
        queue_update(MODE_PRICE, 32'd0, 32'd0, VOL_MAX + 32'd1, 64'd0);
        queue_update(MODE_PRICE, '1, '1, '1, 64'd0);
        queue_update(MODE_PRICE, 32'd1, 32'd1, 32'd1, 64'd0);
        queue_update(MODE_PRICE, 32'd100500, 32'd10000001, 32'd9000000, 64'd0);
        queue_update(MODE_PRICE, 32'd7, 32'd1234, 32'd56, 64'd0);
        queue_update(MODE_PRICE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 64'd0);

        // Totalizer mode: zero with prices ignored, the split between groups, maximum,
        // first overflow and full width.
        queue_update(MODE_TOTAL, '1, '1, '1, 64'd0);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, 64'd1);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, 64'd999999);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, 64'd1000000);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, 64'd1234567890123);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, TZ_MAX);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, TZ_MAX + 64'd1);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, '1);
        queue_update(MODE_TOTAL, 32'd0, 32'd0, 32'd0, 64'h5555_5555_5555_5555);

        // Random updates; fields not shown in the chosen mode get random values too.
        for (i = 0; i < RANDOM_UPDATES; i++)
        begin
            u.opcode     = ($urandom_range(0, 4) < 3) ? MODE_PRICE : MODE_TOTAL;
            u.unit_rate  = 32'(random_shown_value(UP_DIGITS, 32));
            u.sale_total = 32'(random_shown_value(TP_DIGITS, 32));
            u.volume     = 32'(random_shown_value(VOL_DIGITS, 32));
            u.totalizer  = random_shown_value(DIGITS, 64);
            pending_updates.push_back(u);
        end
        total_updates = pending_updates.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (updates_taken < total_updates)
            @(posedge clk);
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial
    begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

endmodule
